### hdl/tas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid angle sweep package
// Widths, register indexes and the structs shared by the sweep modules.
// ----------------------------------------------------------------------------
package tas_pkg;

    // Field widths.
    localparam int TIME_BITS  = 16;
    localparam int ANGLE_BITS = 16;

    // Phase accumulator, pre-wrap sum and product widths.
    localparam int PHASE_W = TIME_BITS + 2;
    localparam int SUM_W   = PHASE_W + 1;
    localparam int PROD_W  = ANGLE_BITS + TIME_BITS;

    // Iteration counts of the two serial dividers.
    localparam int MOD_STEPS = SUM_W;
    localparam int DIV_STEPS = ANGLE_BITS;
    localparam int STEP_MAX  = (MOD_STEPS > DIV_STEPS) ? MOD_STEPS : DIV_STEPS;
    localparam int CNT_W     = $clog2(STEP_MAX);

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int IDX_W      = 2;
    localparam int APB_ADDR_W = IDX_W + 2;

    localparam logic [IDX_W-1:0] REG_START_ANGLE = 2'd0;
    localparam logic [IDX_W-1:0] REG_END_ANGLE   = 2'd1;
    localparam logic [IDX_W-1:0] REG_RAMP        = 2'd2;
    localparam logic [IDX_W-1:0] REG_HOLD        = 2'd3;

    // Configuration register contents.
    typedef struct packed {
        logic [ANGLE_BITS-1:0] start_angle;
        logic [ANGLE_BITS-1:0] end_angle;
        logic [TIME_BITS-1:0]  ramp;
        logic [TIME_BITS-1:0]  hold;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mod_step;
        logic seg;
        logic mul;
        logic div_step;
        logic fin;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic period_zero;
        logic ramp_seg;
        logic out_free;
    } t_sts;

endpackage

### hdl/trapezoid_angle_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid angle sweep
// Phase accumulator driving a hold, ramp, hold, ramp-back angle profile.
// ----------------------------------------------------------------------------
// Each input item is one elapsed-time tick and yields one angle item. The
// block works on one item at a time and accepts the next only once the last
// has been written to the output register. A zero period goes straight to
// the result; other items pass through the serial restoring divider that
// wraps the 19-bit phase sum by the period one bit a cycle, and ramp items
// then through the 16-step divider that divides the product of the angle
// difference magnitude and the ramp offset by the ramp length.
// The result sits in an output register. A result waiting
// there does not stop the next item from being accepted and worked on; that
// item then waits in its final step, with the input not ready, until the
// output register is free. Configuration registers are at byte addresses 0,
// 4, 8 and 12 (start angle, end angle, ramp duration, hold duration) and
// should be written only while no item is in flight.
// ----------------------------------------------------------------------------
module trapezoid_angle_sweep (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tas_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tas_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tas_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [tas_pkg::TIME_BITS-1:0]    i_elapsed,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [tas_pkg::ANGLE_BITS-1:0]   o_angle
);
    import tas_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    // Configuration registers.
    tas_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer.
    tas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and output register.
    tas_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .i_elapsed   (i_elapsed),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_angle     (o_angle)
    );

endmodule

### hdl/tas_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid angle sweep configuration registers
// APB-style register file holding the angles and durations of the sweep.
// ----------------------------------------------------------------------------
module tas_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tas_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tas_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tas_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output tas_pkg::t_cfg                    o_cfg
);
    import tas_pkg::*;

    t_cfg             r_cfg;
    t_cfg             n_cfg;
    logic [IDX_W-1:0] w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;

    // Register write decode; extra data bits are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_START_ANGLE: n_cfg.start_angle = pwdata[ANGLE_BITS-1:0];
                REG_END_ANGLE:   n_cfg.end_angle   = pwdata[ANGLE_BITS-1:0];
                REG_RAMP:        n_cfg.ramp        = pwdata[TIME_BITS-1:0];
                REG_HOLD:        n_cfg.hold        = pwdata[TIME_BITS-1:0];
                default:         n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (w_idx)
            REG_START_ANGLE: prdata = APB_DATA_W'(r_cfg.start_angle);
            REG_END_ANGLE:   prdata = APB_DATA_W'(r_cfg.end_angle);
            REG_RAMP:        prdata = APB_DATA_W'(r_cfg.ramp);
            REG_HOLD:        prdata = APB_DATA_W'(r_cfg.hold);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/tas_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid angle sweep controller
// Sequences the phase wrap, segment decode, multiply and ramp division.
// ----------------------------------------------------------------------------
module tas_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tas_pkg::t_sts i_sts,
    output tas_pkg::t_cmd o_cmd
);
    import tas_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_SEG  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state, step counter and datapath commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.period_zero) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_MOD;
                        n_cnt   = CNT_W'(MOD_STEPS - 1);
                    end
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_SEG;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_SEG: begin
                o_cmd.seg = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                // Hold segments need no interpolation.
                if (i_sts.ramp_seg) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_DIV;
                    n_cnt     = CNT_W'(DIV_STEPS - 1);
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // An item with a nonzero period always starts the phase wrap.
    a_start_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !i_sts.period_zero |=> r_state == S_MOD)
        else $error("item accepted but phase wrap not started");

    // A zero period goes straight to the result.
    a_zero_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_sts.period_zero |=> r_state == S_FIN)
        else $error("zero period item did not go to result");

    // The last division step hands over to the result.
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV && r_cnt == '0 |=> r_state == S_FIN)
        else $error("division did not end after its last step");

endmodule

### hdl/tas_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid angle sweep datapath
// Phase accumulator, serial modulo, segment decode, ramp interpolation
// divider and the output register.
// ----------------------------------------------------------------------------
module tas_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tas_pkg::t_cfg                   i_cfg,
    input  tas_pkg::t_cmd                   i_cmd,
    input  logic [tas_pkg::TIME_BITS-1:0]   i_elapsed,
    input  logic                            i_out_ready,
    output tas_pkg::t_sts                   o_sts,
    output logic                            o_out_valid,
    output logic [tas_pkg::ANGLE_BITS-1:0]  o_angle
);
    import tas_pkg::*;

    logic [PHASE_W-1:0]    r_phase,  n_phase;
    logic [SUM_W-1:0]      r_num,    n_num;
    logic [PHASE_W-1:0]    r_rem,    n_rem;
    logic [ANGLE_BITS-1:0] r_from,   n_from;
    logic                  r_neg,    n_neg;
    logic                  r_ramp_seg, n_ramp_seg;
    logic [ANGLE_BITS-1:0] r_mag,    n_mag;
    logic [TIME_BITS-1:0]  r_off,    n_off;
    logic [TIME_BITS-1:0]  r_drem,   n_drem;
    logic [ANGLE_BITS-1:0] r_dq,     n_dq;
    logic [ANGLE_BITS-1:0] r_out_angle, n_out_angle;
    logic                  r_out_valid, n_out_valid;

    logic [PHASE_W-1:0]    w_period;
    logic [SUM_W-1:0]      w_sum;
    logic [PHASE_W:0]      w_mod_sh;
    logic [TIME_BITS:0]    w_div_sh;
    logic [ANGLE_BITS:0]   w_diff;
    logic [ANGLE_BITS:0]   w_ndiff;
    logic [ANGLE_BITS-1:0] w_mag;
    logic [PHASE_W-1:0]    w_b1, w_b2, w_b3;
    logic [PHASE_W-1:0]    w_off1, w_off3;
    logic [ANGLE_BITS:0]   w_fin;
    logic [PROD_W-1:0]     w_prod;

    // Period and the pre-wrap phase sum.
    assign w_period = PHASE_W'({i_cfg.ramp, 1'b0}) + PHASE_W'({i_cfg.hold, 1'b0});
    assign w_sum    = SUM_W'(r_phase) + SUM_W'(i_elapsed);

    // One restoring step of each serial divider.
    assign w_mod_sh = {r_rem, r_num[SUM_W-1]};
    assign w_div_sh = {r_drem, r_dq[ANGLE_BITS-1]};

    // Angle difference and its magnitude.
    assign w_diff  = {i_cfg.end_angle[ANGLE_BITS-1], i_cfg.end_angle}
                   - {i_cfg.start_angle[ANGLE_BITS-1], i_cfg.start_angle};
    assign w_ndiff = (ANGLE_BITS + 1)'(0) - w_diff;
    assign w_mag   = w_diff[ANGLE_BITS] ? w_ndiff[ANGLE_BITS-1:0]
                                        : w_diff[ANGLE_BITS-1:0];

    // Segment boundaries and ramp offsets within the wrapped phase.
    assign w_b1   = PHASE_W'(i_cfg.hold);
    assign w_b2   = w_b1 + PHASE_W'(i_cfg.ramp);
    assign w_b3   = w_b2 + PHASE_W'(i_cfg.hold);
    assign w_off1 = r_rem - w_b1;
    assign w_off3 = r_rem - w_b3;

    assign w_prod = PROD_W'(r_mag) * PROD_W'(r_off);

    // Ramp value: the leaving angle moved by the scaled quotient.
    assign w_fin = r_neg ? ({r_from[ANGLE_BITS-1], r_from} - {1'b0, r_dq})
                         : ({r_from[ANGLE_BITS-1], r_from} + {1'b0, r_dq});

    always_comb begin
        n_phase     = r_phase;
        n_num       = r_num;
        n_rem       = r_rem;
        n_from      = r_from;
        n_neg       = r_neg;
        n_ramp_seg  = r_ramp_seg;
        n_mag       = r_mag;
        n_off       = r_off;
        n_drem      = r_drem;
        n_dq        = r_dq;
        n_out_angle = r_out_angle;
        n_out_valid = r_out_valid;

        // Capture the sum of the new item.
        if (i_cmd.load) begin
            n_num      = w_sum;
            n_rem      = '0;
            n_from     = i_cfg.start_angle;
            n_ramp_seg = 1'b0;
            if (w_period == '0) begin
                n_phase = '0;
            end
        end

        // Wrap the sum by the period, one bit a cycle.
        if (i_cmd.mod_step) begin
            if (w_mod_sh >= {1'b0, w_period}) begin
                n_rem = PHASE_W'(w_mod_sh - {1'b0, w_period});
            end else begin
                n_rem = w_mod_sh[PHASE_W-1:0];
            end
            n_num = {r_num[SUM_W-2:0], 1'b0};
        end

        // Decode the segment of the wrapped phase.
        if (i_cmd.seg) begin
            n_phase = r_rem;
            n_mag   = w_mag;
            priority if (r_rem < w_b1) begin
                n_from     = i_cfg.start_angle;
                n_ramp_seg = 1'b0;
            end else if (r_rem < w_b2) begin
                n_from     = i_cfg.start_angle;
                n_ramp_seg = 1'b1;
                n_neg      = w_diff[ANGLE_BITS];
                n_off      = w_off1[TIME_BITS-1:0];
            end else if (r_rem < w_b3) begin
                n_from     = i_cfg.end_angle;
                n_ramp_seg = 1'b0;
            end else begin
                n_from     = i_cfg.end_angle;
                n_ramp_seg = 1'b1;
                n_neg      = (w_diff != '0) && !w_diff[ANGLE_BITS];
                n_off      = w_off3[TIME_BITS-1:0];
            end
        end

        // The high half of the product is already below the ramp length.
        if (i_cmd.mul) begin
            n_drem = w_prod[PROD_W-1:ANGLE_BITS];
            n_dq   = w_prod[ANGLE_BITS-1:0];
        end

        // Divide the product by the ramp length, one quotient bit a cycle.
        if (i_cmd.div_step) begin
            if (w_div_sh >= {1'b0, i_cfg.ramp}) begin
                n_drem = TIME_BITS'(w_div_sh - {1'b0, i_cfg.ramp});
                n_dq   = {r_dq[ANGLE_BITS-2:0], 1'b1};
            end else begin
                n_drem = w_div_sh[TIME_BITS-1:0];
                n_dq   = {r_dq[ANGLE_BITS-2:0], 1'b0};
            end
        end

        // Output register.
        if (i_cmd.fin) begin
            n_out_angle = r_ramp_seg ? w_fin[ANGLE_BITS-1:0] : r_from;
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_ramp_seg  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_ramp_seg  <= n_ramp_seg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num       <= n_num;
        r_rem       <= n_rem;
        r_from      <= n_from;
        r_neg       <= n_neg;
        r_mag       <= n_mag;
        r_off       <= n_off;
        r_drem      <= n_drem;
        r_dq        <= n_dq;
        r_out_angle <= n_out_angle;
    end

    assign o_sts.period_zero = (w_period == '0);
    assign o_sts.ramp_seg    = r_ramp_seg;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_angle           = r_out_angle;

    // A result appears only from a finish command.
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.fin))
        else $error("result appeared without a finish command");

    // A zero period clears the phase.
    a_zero_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load && o_sts.period_zero |=> r_phase == '0)
        else $error("phase not cleared for zero period");

    // Hold segments give the held angle unchanged.
    a_hold_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin && !r_ramp_seg |=> r_out_angle == $past(r_from))
        else $error("hold segment angle altered");

endmodule

### test/tb_trapezoid_angle_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid angle sweep testbench
// Sends elapsed-time ticks through the sweep block and checks every angle
// against a phase-tracking predictor. Covers a directed pass over the
// segment boundaries and the degenerate profiles, then random profiles with
// random ticks. Both handshakes stall at random, and one long output stall
// backs the block up.
// ----------------------------------------------------------------------------
module tb_trapezoid_angle_sweep;
    import tas_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SWEEP_PHASES  = 25;
    localparam int TICKS_PER_SET = 50;
    localparam int HOLD_OFF_AT   = 300;
    localparam int HOLD_OFF_LEN  = 400;
    localparam int DRAIN_CYCLES  = 60;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    psel        = 1'b0;
    logic                    penable     = 1'b0;
    logic                    pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr       = '0;
    logic [APB_DATA_W-1:0]   pwdata      = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    logic [TIME_BITS-1:0]    i_elapsed   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [ANGLE_BITS-1:0]   o_angle;

    // Copy of the register file and the phase accumulator.
    logic signed [ANGLE_BITS-1:0] cfg_start = '0;
    logic signed [ANGLE_BITS-1:0] cfg_end   = '0;
    logic [TIME_BITS-1:0]         cfg_ramp  = '0;
    logic [TIME_BITS-1:0]         cfg_hold  = '0;
    logic [PHASE_W-1:0]           phase_acc = '0;

    logic [TIME_BITS-1:0]  tick_queue[$];
    logic [ANGLE_BITS-1:0] angle_expect[$];
    logic [ANGLE_BITS-1:0] angle_head;

    int send_idle_pct = 30;
    int recv_idle_pct = 45;
    int mismatches    = 0;
    int results_seen  = 0;
    int hold_off_left = 0;
    bit hold_off_done = 1'b0;
    int cycle_count   = 0;

    trapezoid_angle_sweep i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_elapsed   (i_elapsed),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_angle     (o_angle)
    );

    always #10 i_clk = ~i_clk;

    // Advances the phase by one tick and returns the angle at the new phase.
    function automatic logic [ANGLE_BITS-1:0] sweep_step(input logic [TIME_BITS-1:0] tick);
        longint ramp, hold, period, t, a0, a1, from, delta, part, off;
        ramp   = cfg_ramp;
        hold   = cfg_hold;
        period = 2 * ramp + 2 * hold;
        a0     = cfg_start;
        a1     = cfg_end;
        if (period == 0) begin
            phase_acc = '0;
            return cfg_start;
        end
        t = (phase_acc + tick) % period;
        phase_acc = t[PHASE_W-1:0];
        if (t < hold)
            return cfg_start;
        if (t >= hold + ramp && t < 2 * hold + ramp)
            return cfg_end;
        // Rising ramp leaves the start angle, falling ramp leaves the end angle.
        if (t < hold + ramp) begin
            from  = a0;
            delta = a1 - a0;
            off   = t - hold;
        end else begin
            from  = a1;
            delta = a0 - a1;
            off   = t - 2 * hold - ramp;
        end
        // Scale the magnitude so that the quotient truncates toward zero.
        part = ((delta < 0 ? -delta : delta) * off) / ramp;
        from = (delta < 0) ? from - part : from + part;
        return from[ANGLE_BITS-1:0];
    endfunction

    // One register write: setup cycle, then access cycle. Upper bits are noise.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & 32'hffff_0000) | {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START_ANGLE: cfg_start = value;
            REG_END_ANGLE:   cfg_end   = value;
            REG_RAMP:        cfg_ramp  = value;
            REG_HOLD:        cfg_hold  = value;
            default: ;
        endcase
    endtask

    // Writes a profile; unless every register is forced, each is skipped now and then.
    task automatic write_profile(input logic [15:0] a0, input logic [15:0] a1,
                                 input logic [15:0] ramp, input logic [15:0] hold,
                                 input bit every_reg);
        if (every_reg || $urandom_range(3) != 0) write_reg(REG_START_ANGLE, a0);
        if (every_reg || $urandom_range(3) != 0) write_reg(REG_END_ANGLE, a1);
        if (every_reg || $urandom_range(3) != 0) write_reg(REG_RAMP, ramp);
        if (every_reg || $urandom_range(3) != 0) write_reg(REG_HOLD, hold);
    endtask

    // Waits until every queued tick has gone in and every angle has come out.
    task automatic wait_drained();
        while (tick_queue.size() != 0 || i_in_valid || angle_expect.size() != 0)
            @(posedge i_clk);
    endtask

    // Appends one tick to the end of the pending queue.
    function automatic void queue_tick(input logic [TIME_BITS-1:0] tick);
        tick_queue.insert(tick_queue.size(), tick);
    endfunction

    function automatic logic [15:0] pick_duration();
        case ($urandom_range(5))
            0:       return 16'd0;
            1:       return 16'hffff;
            2, 3:    return 16'($urandom_range(1, 20));
            4:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 300));
        endcase
    endfunction

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(4))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom_range(0, 100) - 50);
            default: return 16'($urandom());
        endcase
    endfunction

    // Mostly ticks short against the period so that every segment is visited.
    function automatic logic [15:0] pick_tick();
        int period, span;
        period = 2 * int'(cfg_ramp) + 2 * int'(cfg_hold);
        span   = (period == 0) ? 65535 : period / 3 + 1;
        if (span > 65535)
            span = 65535;
        if ($urandom_range(3) == 0)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, span));
    endfunction

    // Input driver: offers queued ticks and predicts each accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid)
                angle_expect.insert(angle_expect.size(), sweep_step(i_elapsed));
            if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_elapsed  <= tick_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each angle item and drives the receiver's ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (angle_expect.size() == 0) begin
                    $display("%0t: unexpected angle item, expected none, actual %0d", $time,
                             $signed(o_angle));
                    mismatches++;
                end else begin
                    angle_head = angle_expect.pop_front();
                    if (angle_head !== o_angle) begin
                        $display("%0t: angle mismatch, expected %0d, actual %0d", $time,
                                 $signed(angle_head), $signed(o_angle));
                        mismatches++;
                    end
                end
            end
            // One long stall part way through, so that the block backs up.
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_out_ready <= 1'b0;
            end else if (results_seen == HOLD_OFF_AT && !hold_off_done) begin
                hold_off_done = 1'b1;
                hold_off_left = HOLD_OFF_LEN;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("trapezoid_angle_sweep test failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        int p, k;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers still at reset: zero period, so the start angle holds.
        queue_tick(16'd0);
        queue_tick(16'hffff);
        queue_tick(16'd1);
        wait_drained();

        // Widest profile and the full angle span, stepped across each boundary.
        write_profile(16'h8000, 16'h7fff, 16'hffff, 16'hffff, 1'b1);
        queue_tick(16'hffff);
        queue_tick(16'd32768);
        queue_tick(16'd32767);
        queue_tick(16'hffff);
        queue_tick(16'hffff);
        queue_tick(16'hffff);
        queue_tick(16'hffff);
        wait_drained();

        // Zero ramp with a hold: the ramps vanish. Old phase wraps on the new period.
        write_profile(16'd100, -16'sd200, 16'd0, 16'd5, 1'b1);
        queue_tick(16'd3);
        queue_tick(16'd4);
        queue_tick(16'd7);
        queue_tick(16'd1);
        wait_drained();

        // No hold and a falling sweep between the angle extremes.
        write_profile(16'h7fff, 16'h8000, 16'd7, 16'd0, 1'b1);
        for (k = 1; k <= 9; k += 2)
            queue_tick(16'(k));
        wait_drained();

        // Random profiles; idling shifts from one side to the other, then stops.
        for (p = 0; p < SWEEP_PHASES; p++) begin
            if (p < SWEEP_PHASES / 3) begin
                send_idle_pct = 30;
                recv_idle_pct = 45;
            end else if (p < 2 * SWEEP_PHASES / 3) begin
                send_idle_pct = 45;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_profile(pick_angle(), pick_angle(), pick_duration(), pick_duration(),
                          1'b0);
            for (k = 0; k < TICKS_PER_SET; k++)
                queue_tick(pick_tick());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && angle_expect.size() == 0)
            $display("trapezoid_angle_sweep test passed");
        else
            $display("trapezoid_angle_sweep test failed");
        $finish;
    end

endmodule
